/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the queue and packer modules of the Huffman bit packer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HCBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define HCBP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define HCBP_ASSERT(lbl, prop, msg)
`define HCBP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* hw/rtl/hcbp_pkg.sv */
// Shared constants and types of the Huffman code bit packer.
package hcbp_pkg;

  localparam int unsigned SymW      = 8;
  localparam int unsigned Symbols   = 2 ** SymW;
  localparam int unsigned CodeW     = 32;
  localparam int unsigned LenW      = 6;
  localparam int unsigned MaxCodeLen = 32;
  localparam int unsigned LenLimit  = (MaxCodeLen < CodeW) ? MaxCodeLen : CodeW;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned AccW      = CodeW + ByteW;
  localparam int unsigned CntW      = $clog2(AccW);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW     = $clog2(QueueDepth);
  localparam int unsigned QCntW     = $clog2(QueueDepth + 1);

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_ENCODE = 1'b1;

  typedef struct packed {
    logic [CodeW-1:0] word;
    logic [LenW-1:0]  len;
  } tbl_entry_t;

  typedef struct packed {
    logic [CodeW-1:0] word;
    logic [LenW-1:0]  len;
    logic             fin;
  } enc_item_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

/* hw/rtl/huffman_code_bit_packer.sv */
// Top level of the Huffman code bit packer: front end, work queue and byte packer.
// A load transfer writes one code table entry; an encode transfer reads its table entry
// into a stage register at acceptance and enters a two-entry queue once the queue has room,
// then the packer merges its code with the pending bits and emits one output byte at a
// time (zero to five); the packer takes no new item until it has emitted this one's last byte.
// With nothing ahead of it, an item passes the stage register, a queue slot, the bit
// accumulator and the output register before its first byte is presented. The output
// register holds a stalled byte while the packer may still merge the next code.
module huffman_code_bit_packer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        req_type_i,
  input  logic [hcbp_pkg::SymW-1:0]   symbol_i,
  input  logic [hcbp_pkg::CodeW-1:0]  code_word_i,
  input  logic [hcbp_pkg::LenW-1:0]   code_len_i,
  input  logic                        final_symbol_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [hcbp_pkg::ByteW-1:0]  out_byte_o,
  output logic                        run_end_o,
  output logic                        stream_end_o
);

  hcbp_pkg::q_status_t q_status;
  hcbp_pkg::enc_item_t push_item;
  hcbp_pkg::enc_item_t head_item;
  logic                push;
  logic                pop;

  hcbp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .symbol_i       (symbol_i),
    .code_word_i    (code_word_i),
    .code_len_i     (code_len_i),
    .final_symbol_i (final_symbol_i),
    .q_status_i     (q_status),
    .push_o         (push),
    .push_item_o    (push_item)
  );

  hcbp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .status_o    (q_status),
    .head_o      (head_item)
  );

  hcbp_packer u_packer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_status_i   (q_status),
    .q_head_i     (head_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .run_end_o    (run_end_o),
    .stream_end_o (stream_end_o)
  );

endmodule

/* hw/rtl/hcbp_front.sv */
// Front end: takes input transfers, keeps the code table and queues encode work.
module hcbp_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         req_type_i,
  input  logic [hcbp_pkg::SymW-1:0]    symbol_i,
  input  logic [hcbp_pkg::CodeW-1:0]   code_word_i,
  input  logic [hcbp_pkg::LenW-1:0]    code_len_i,
  input  logic                         final_symbol_i,
  input  hcbp_pkg::q_status_t          q_status_i,
  output logic                         push_o,
  output hcbp_pkg::enc_item_t          push_item_o
);

  hcbp_pkg::tbl_entry_t tbl_mem [hcbp_pkg::Symbols];
  hcbp_pkg::tbl_entry_t rd_q;
  logic                 fin_q;
  logic                 stage_valid_q, stage_valid_d;
  logic                 accept;
  logic                 acc_load, acc_enc;
  logic [hcbp_pkg::LenW-1:0] len_sat;

  assign in_stall_o = stage_valid_q && q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign acc_load   = accept && (req_type_i == hcbp_pkg::REQ_LOAD);
  assign acc_enc    = accept && (req_type_i == hcbp_pkg::REQ_ENCODE);
  assign len_sat    = (code_len_i > hcbp_pkg::LenW'(hcbp_pkg::LenLimit)) ?
                      hcbp_pkg::LenW'(hcbp_pkg::LenLimit) : code_len_i;

  assign push_o      = stage_valid_q && !q_status_i.full;
  assign push_item_o = '{word: rd_q.word, len: rd_q.len, fin: fin_q};

  always_comb begin
    stage_valid_d = acc_enc || (stage_valid_q && q_status_i.full);
  end

  always_ff @(posedge clk_i) begin
    if (acc_load) begin
      tbl_mem[symbol_i] <= '{word: code_word_i, len: len_sat};
    end
    if (acc_enc) begin
      rd_q  <= tbl_mem[symbol_i];
      fin_q <= final_symbol_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

endmodule

/* hw/rtl/hcbp_queue.sv */
// Two-entry queue of encode work between the front end and the packer.
`include "assert_macros.svh"
module hcbp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hcbp_pkg::enc_item_t push_item_i,
  input  logic                pop_i,
  output hcbp_pkg::q_status_t status_o,
  output hcbp_pkg::enc_item_t head_o
);

  hcbp_pkg::enc_item_t          slots_q [hcbp_pkg::QueueDepth];
  logic [hcbp_pkg::QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [hcbp_pkg::QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [hcbp_pkg::QCntW-1:0]   cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == hcbp_pkg::QCntW'(hcbp_pkg::QueueDepth));
  assign status_o.valid = (cnt_q != '0);
  assign head_o         = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + hcbp_pkg::QCntW'(push_i) - hcbp_pkg::QCntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `HCBP_ASSERT_ALWAYS(a_q_no_overflow,
    (!rst_ni || (cnt_q <= hcbp_pkg::QCntW'(hcbp_pkg::QueueDepth))), "Queue count exceeds depth.")
  `HCBP_ASSERT(a_q_no_underflow, (pop_i |-> cnt_q != '0), "Pop from an empty queue.")
  `HCBP_ASSERT(a_q_push_room, (push_i |-> !status_o.full), "Push into a full queue.")

endmodule

/* hw/rtl/hcbp_packer.sv */
// Back end: packs code bits MSB-first into bytes and drives the output transfer.
`include "assert_macros.svh"
module hcbp_packer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hcbp_pkg::q_status_t         q_status_i,
  input  hcbp_pkg::enc_item_t         q_head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [hcbp_pkg::ByteW-1:0]  out_byte_o,
  output logic                        run_end_o,
  output logic                        stream_end_o
);

  localparam logic [hcbp_pkg::CntW-1:0] ByteCnt = hcbp_pkg::CntW'(hcbp_pkg::ByteW);
  localparam logic [hcbp_pkg::CntW-1:0] TwoByteCnt = hcbp_pkg::CntW'(2 * hcbp_pkg::ByteW);

  logic [hcbp_pkg::AccW-1:0]  acc_q, acc_d;
  logic [hcbp_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic                       fin_q, fin_d;
  logic                       busy_q, busy_d;
  logic                       out_valid_q, out_valid_d;
  logic [hcbp_pkg::ByteW-1:0] byte_q, byte_d;
  logic                       run_end_q, run_end_d;
  logic                       stream_end_q, stream_end_d;
  logic                       out_free;
  logic                       emit_last;
  logic [hcbp_pkg::AccW-1:0]  code_al;
  logic [hcbp_pkg::CntW-1:0]  total;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = !busy_q && q_status_i.valid;

  assign code_al = ({q_head_i.word, hcbp_pkg::ByteW'(0)}
                    << (hcbp_pkg::LenW'(hcbp_pkg::CodeW) - q_head_i.len)) >> cnt_q[2:0];
  assign total   = hcbp_pkg::CntW'(cnt_q[2:0]) + hcbp_pkg::CntW'(q_head_i.len);

  always_comb begin
    acc_d        = acc_q;
    cnt_d        = cnt_q;
    fin_d        = fin_q;
    busy_d       = busy_q;
    out_valid_d  = out_valid_q && out_stall_i;
    byte_d       = byte_q;
    run_end_d    = run_end_q;
    stream_end_d = stream_end_q;
    emit_last    = 1'b1;
    if (pop_o) begin
      acc_d  = acc_q | code_al;
      cnt_d  = total;
      fin_d  = q_head_i.fin;
      busy_d = (total >= ByteCnt) || (q_head_i.fin && (total != '0));
    end else if (busy_q && out_free) begin
      if (cnt_q >= ByteCnt) begin
        emit_last = (cnt_q < TwoByteCnt) && !(fin_q && (cnt_q != ByteCnt));
        cnt_d     = cnt_q - ByteCnt;
      end else begin
        emit_last = 1'b1;
        cnt_d     = '0;
      end
      acc_d        = acc_q << hcbp_pkg::ByteW;
      busy_d       = !emit_last;
      out_valid_d  = 1'b1;
      byte_d       = acc_q[hcbp_pkg::AccW-1 -: hcbp_pkg::ByteW];
      run_end_d    = emit_last;
      stream_end_d = emit_last && fin_q;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q       <= byte_d;
    run_end_q    <= run_end_d;
    stream_end_q <= stream_end_d;
    fin_q        <= fin_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      cnt_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = byte_q;
  assign run_end_o    = run_end_q;
  assign stream_end_o = stream_end_q;

  `HCBP_ASSERT(a_idle_partial, (!busy_q |-> cnt_q < ByteCnt), "Idle packer holds a full byte.")
  `HCBP_ASSERT_ALWAYS(a_cnt_range,
    (!rst_ni || (cnt_q < hcbp_pkg::CntW'(hcbp_pkg::AccW))), "Bit count out of range.")
  `HCBP_ASSERT(a_stream_run, ((out_valid_q && stream_end_q) |-> run_end_q), "Stream end without run end.")

endmodule

/* test/testbench.sv */
// Self-checking testbench for the Huffman code bit packer, with randomized handshakes.
module testbench;

  typedef struct {
    logic                        req;
    logic [hcbp_pkg::SymW-1:0]   sym;
    logic [hcbp_pkg::CodeW-1:0]  word;
    logic [hcbp_pkg::LenW-1:0]   len;
    logic                        fin;
    int                          gap;
  } code_req_t;

  typedef struct packed {
    logic [hcbp_pkg::ByteW-1:0] data;
    logic                       run_last;
    logic                       stream_last;
  } packed_byte_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic                        req_type_i = hcbp_pkg::REQ_LOAD;
  logic [hcbp_pkg::SymW-1:0]   symbol_i = '0;
  logic [hcbp_pkg::CodeW-1:0]  code_word_i = '0;
  logic [hcbp_pkg::LenW-1:0]   code_len_i = '0;
  logic                        final_symbol_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [hcbp_pkg::ByteW-1:0]  out_byte_o;
  logic                        run_end_o;
  logic                        stream_end_o;

  code_req_t            stim_q[$];
  packed_byte_t         expected_bytes[$];
  hcbp_pkg::tbl_entry_t code_book [hcbp_pkg::Symbols];
  logic [hcbp_pkg::ByteW-1:0] acc_bits = '0;
  int                   acc_fill = 0;

  logic in_took = 1'b0;
  logic out_took = 1'b0;
  logic hold_off = 1'b0;
  int   feed_idle = 0;
  int   drain_wait = 0;
  int   items_accepted = 0;
  int   results_seen = 0;
  int   mismatch_count = 0;

  logic [hcbp_pkg::SymW-1:0] loaded_syms[$];
  logic                      sym_loaded [hcbp_pkg::Symbols];

  huffman_code_bit_packer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .symbol_i      (symbol_i),
    .code_word_i   (code_word_i),
    .code_len_i    (code_len_i),
    .final_symbol_i(final_symbol_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .run_end_o     (run_end_o),
    .stream_end_o  (stream_end_o)
  );

  always #6 clk_i = ~clk_i;

  // Loads update the code book; encodes queue MSB-first code bytes, flushing on fin.
  task automatic pack_code_bits(input logic req, input logic [hcbp_pkg::SymW-1:0] sym,
                                input logic [hcbp_pkg::CodeW-1:0] word,
                                input logic [hcbp_pkg::LenW-1:0] len,
                                input logic fin);
    hcbp_pkg::tbl_entry_t ent;
    packed_byte_t made[$];
    packed_byte_t one;
    int           lim;
    int           i;
    lim = (hcbp_pkg::MaxCodeLen < hcbp_pkg::CodeW) ? hcbp_pkg::MaxCodeLen : hcbp_pkg::CodeW;
    if (req == hcbp_pkg::REQ_LOAD) begin
      code_book[sym].word = word;
      code_book[sym].len  = (len > lim) ? hcbp_pkg::LenW'(lim) : len;
      return;
    end
    ent = code_book[sym];
    for (i = ent.len; i > 0; i--) begin
      acc_bits[hcbp_pkg::ByteW-1-acc_fill] = ent.word[i-1];
      acc_fill++;
      if (acc_fill == hcbp_pkg::ByteW) begin
        one = '{data: acc_bits, run_last: 1'b0, stream_last: 1'b0};
        made.push_back(one);
        acc_bits = '0;
        acc_fill = 0;
      end
    end
    if (fin && acc_fill > 0) begin
      one = '{data: acc_bits, run_last: 1'b0, stream_last: 1'b0};
      made.push_back(one);
      acc_bits = '0;
      acc_fill = 0;
    end
    if (made.size() > 0) begin
      made[made.size()-1].run_last = 1'b1;
      if (fin) begin
        made[made.size()-1].stream_last = 1'b1;
      end
    end
    foreach (made[k]) expected_bytes.push_back(made[k]);
  endtask

  task automatic add_item(input logic req, input logic [hcbp_pkg::SymW-1:0] sym,
                          input logic [hcbp_pkg::CodeW-1:0] word,
                          input logic [hcbp_pkg::LenW-1:0] len,
                          input logic fin);
    code_req_t it;
    it.req  = req;
    it.sym  = sym;
    it.word = word;
    it.len  = len;
    it.fin  = fin;
    it.gap  = ((stim_q.size() % 80) < 25) ? 0 : $urandom_range(0, 8);
    stim_q.push_back(it);
    if (req == hcbp_pkg::REQ_LOAD && !sym_loaded[sym]) begin
      sym_loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endtask

  always @(posedge clk_i) begin
    in_took <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pack_code_bits(req_type_i, symbol_i, code_word_i, code_len_i, final_symbol_i);
      items_accepted++;
    end
  end

  always @(negedge clk_i) begin : feed
    code_req_t nxt;
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (stim_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (feed_idle < stim_q[0].gap) begin
        in_valid_i <= 1'b0;
        feed_idle  <= feed_idle + 1;
      end else begin
        nxt = stim_q.pop_front();
        req_type_i     <= nxt.req;
        symbol_i       <= nxt.sym;
        code_word_i    <= nxt.word;
        code_len_i     <= nxt.len;
        final_symbol_i <= nxt.fin;
        in_valid_i     <= 1'b1;
        feed_idle      <= 0;
      end
    end
  end

  always @(posedge clk_i) begin : check
    packed_byte_t want;
    out_took <= rst_ni && out_valid_o && !out_stall_i;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte, expected none, actual %h run_end %b stream_end %b",
                 $time, out_byte_o, run_end_o, stream_end_o);
        mismatch_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte_o !== want.data) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.data, out_byte_o);
          mismatch_count++;
        end
        if (run_end_o !== want.run_last) begin
          $display("%0t: run_end expected %b actual %b", $time, want.run_last, run_end_o);
          mismatch_count++;
        end
        if (stream_end_o !== want.stream_last) begin
          $display("%0t: stream_end expected %b actual %b", $time, want.stream_last,
                   stream_end_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(negedge clk_i) begin : drain
    int w;
    w = drain_wait;
    if (out_took) begin
      w = ((results_seen % 64) < 20) ? 0 : $urandom_range(0, 8);
    end
    if (rst_ni && w > 0) begin
      out_stall_i <= 1'b1;
      drain_wait  <= w - 1;
    end else begin
      out_stall_i <= hold_off;
      drain_wait  <= 0;
    end
  end

  // The receiver holds off long enough for the work queue to fill and stall the input.
  initial begin : long_hold
    while (items_accepted < 160) @(negedge clk_i);
    hold_off <= 1'b1;
    repeat (120) @(negedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #2400000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int                        k;
    int                        r;
    logic [hcbp_pkg::LenW-1:0] len;
    logic [hcbp_pkg::SymW-1:0] sym;
    foreach (sym_loaded[i]) sym_loaded[i] = 1'b0;
    foreach (code_book[i]) code_book[i] = '0;

    add_item(hcbp_pkg::REQ_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd32, 1'b0);
    add_item(hcbp_pkg::REQ_LOAD, 8'd255, 32'h0000_0000, 6'd1, 1'b0);
    add_item(hcbp_pkg::REQ_LOAD, 8'd1, 32'h8000_0001, 6'd63, 1'b1);
    add_item(hcbp_pkg::REQ_LOAD, 8'd2, 32'hDEAD_BEEF, 6'd0, 1'b0);
    add_item(hcbp_pkg::REQ_LOAD, 8'd3, 32'h0000_0005, 6'd3, 1'b0);
    add_item(hcbp_pkg::REQ_LOAD, 8'd4, 32'h0000_007F, 6'd7, 1'b0);
    add_item(hcbp_pkg::REQ_LOAD, 8'd128, 32'h1234_5678, 6'd40, 1'b0);
    add_item(hcbp_pkg::REQ_ENCODE, 8'd2, $urandom, hcbp_pkg::LenW'($urandom), 1'b1);
    add_item(hcbp_pkg::REQ_ENCODE, 8'd3, $urandom, hcbp_pkg::LenW'($urandom), 1'b0);
    add_item(hcbp_pkg::REQ_ENCODE, 8'd0, $urandom, hcbp_pkg::LenW'($urandom), 1'b0);
    add_item(hcbp_pkg::REQ_ENCODE, 8'd4, $urandom, hcbp_pkg::LenW'($urandom), 1'b0);
    add_item(hcbp_pkg::REQ_ENCODE, 8'd3, $urandom, hcbp_pkg::LenW'($urandom), 1'b1);
    add_item(hcbp_pkg::REQ_ENCODE, 8'd4, $urandom, hcbp_pkg::LenW'($urandom), 1'b0);
    add_item(hcbp_pkg::REQ_ENCODE, 8'd0, $urandom, hcbp_pkg::LenW'($urandom), 1'b1);
    add_item(hcbp_pkg::REQ_ENCODE, 8'd3, $urandom, hcbp_pkg::LenW'($urandom), 1'b0);
    add_item(hcbp_pkg::REQ_ENCODE, 8'd2, $urandom, hcbp_pkg::LenW'($urandom), 1'b1);
    add_item(hcbp_pkg::REQ_ENCODE, 8'd255, $urandom, hcbp_pkg::LenW'($urandom), 1'b1);
    add_item(hcbp_pkg::REQ_ENCODE, 8'd0, $urandom, hcbp_pkg::LenW'($urandom), 1'b1);
    add_item(hcbp_pkg::REQ_ENCODE, 8'd1, $urandom, hcbp_pkg::LenW'($urandom), 1'b0);
    add_item(hcbp_pkg::REQ_ENCODE, 8'd128, $urandom, hcbp_pkg::LenW'($urandom), 1'b1);
    add_item(hcbp_pkg::REQ_LOAD, 8'd3, 32'h2AAA_AAAA, 6'd31, 1'b0);
    add_item(hcbp_pkg::REQ_ENCODE, 8'd3, $urandom, hcbp_pkg::LenW'($urandom), 1'b1);

    for (k = 0; k < 320; k++) begin
      if (loaded_syms.size() < 12 || $urandom_range(0, 3) == 0) begin
        r = $urandom_range(0, 9);
        case (r)
          0: len = 6'd0;
          1: len = 6'd32;
          2: len = 6'($urandom_range(33, 63));
          3, 4: len = 6'($urandom_range(9, 31));
          default: len = 6'($urandom_range(1, 8));
        endcase
        add_item(hcbp_pkg::REQ_LOAD, 8'($urandom_range(0, 255)), $urandom, len,
                 1'($urandom_range(0, 1)));
      end else begin
        sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        add_item(hcbp_pkg::REQ_ENCODE, sym, $urandom, hcbp_pkg::LenW'($urandom),
                 ($urandom_range(0, 9) == 0));
      end
    end
    add_item(hcbp_pkg::REQ_ENCODE, loaded_syms[0], $urandom, hcbp_pkg::LenW'($urandom), 1'b1);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_bytes.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
